[hw/rtl/sfdt_pkg.sv]
// ----------------------------------------------------------------------------
// sfdt_pkg
// shared constants and codes for the save file directory table
// ----------------------------------------------------------------------------
package sfdt_pkg;

    localparam int ENTRIES    = 256;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int META_W     = 16 + 32 + 32;

    localparam int IN_W  = 352;  // 345 bits of fields, padded to bytes
    localparam int OUT_W = 96;   // 91 bits of fields, padded to bytes

    localparam logic [31:0] DATA_START_RST = 32'd32768;
    localparam logic [15:0] FILE_GAP_RST   = 16'd512;

    // configuration register indexes
    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_FILE_GAP   = 1'b1;

    typedef enum logic [2:0] {
        FN_OPEN_NAME = 3'd0,
        FN_OPEN_NUM  = 3'd1,
        FN_CREATE    = 3'd2,
        FN_DELETE    = 3'd3,
        FN_ACCESS    = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_NO_FILE = 2'd1,
        ST_EXISTS  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] number;
        logic [31:0] length;
        logic [31:0] raw;
    } meta_t;

endpackage

[hw/rtl/save_file_directory_table.sv]
// ----------------------------------------------------------------------------
// save_file_directory_table
// directory of emulated save files: open, create, delete and address access
// ----------------------------------------------------------------------------
// Every item takes one full pass over all 256 slots. The slot memories are
// read once per cycle, slot 0 upward, and each slot's words are examined in
// the following cycle. The result is offered after the read pass (S_SCAN), a
// pipeline step (S_DRAIN), a commit step (S_COMMIT) and the load of the output
// register (S_FINISH). The next item is accepted only in S_IDLE after that, so
// the block takes no new item while one is still being processed.
// The pass finds the first name or number match (as the function selects)
// and the first free slot, and runs the order-dependent numbering and
// placement scans. A create or delete then writes its slot back in the
// commit cycle. Only one item is in flight. A finished result moves into
// the output register and the block takes the next item at once; that next
// result is held back until the previous one has been taken. Slot data live
// in two memories (metadata and name) with a registered read. A valid bit
// per slot makes never-written slots read as empty, so reset needs no
// clearing pass. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module save_file_directory_table (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [31:0]                  cfg_data,
    // request items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // func, file_number, name_word0..3, name_length, size, offset
    input  logic [sfdt_pkg::IN_W-1:0]    s_axis_tdata,
    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status, slot_index, found_number, file_length, raw_address, sync_needed
    output logic [sfdt_pkg::OUT_W-1:0]   m_axis_tdata
);
    import sfdt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [31:0] data_start_reg;
    logic [15:0] file_gap_reg;

    // request fields
    logic [2:0]        in_func;
    logic [15:0]       in_number;
    logic [NAME_W-1:0] in_name;
    logic [5:0]        in_name_len;
    logic [31:0]       in_size;
    logic [31:0]       in_offset;

    assign in_func     = s_axis_tdata[2:0];
    assign in_number   = s_axis_tdata[18:3];
    assign in_name     = s_axis_tdata[274:19];
    assign in_name_len = s_axis_tdata[280:275];
    assign in_size     = s_axis_tdata[312:281];
    assign in_offset   = s_axis_tdata[344:313];

    // latched request
    logic [2:0]        func_reg;
    logic [15:0]       number_reg;
    logic [NAME_W-1:0] qname_reg;
    logic [NAME_W-1:0] qmask_reg;
    logic [31:0]       size_reg;
    logic [31:0]       offset_reg;

    // query mask: bytes before the length limit and the first zero byte
    logic [NAME_W-1:0] qmask_calc;
    logic [6:0]        qlen_lim;
    always_comb
    begin
        logic run;
        run = 1'b1;
        qlen_lim = (in_name_len > 6'(NAME_BYTES)) ? 7'(NAME_BYTES) : {1'b0, in_name_len};
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            run = run && (7'(k) < qlen_lim) && (in_name[k*8 +: 8] != 8'h00);
            qmask_calc[k*8 +: 8] = {8{run}};
        end
    end

    // slot memories
    logic [META_W-1:0] meta_mem [ENTRIES];
    logic [NAME_W-1:0] name_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [META_W-1:0] meta_rd_reg;
    logic [NAME_W-1:0] name_rd_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [META_W-1:0] wr_meta;
    logic [NAME_W-1:0] wr_name;

    always_ff @(posedge clk)
    begin
        meta_rd_reg <= meta_mem[rd_addr];
        name_rd_reg <= name_mem[rd_addr];
        if (wr_en)
        begin
            meta_mem[wr_addr] <= wr_meta;
            name_mem[wr_addr] <= wr_name;
        end
    end

    // scan pipeline
    logic [IDX_W-1:0] scan_addr_reg;
    logic             proc_vld_reg;
    logic [IDX_W-1:0] proc_idx_reg;

    assign rd_addr = scan_addr_reg;

    // slot as seen by the scan, empty when never written
    meta_t             cur_meta;
    logic [NAME_W-1:0] cur_name;
    assign cur_meta = valid_reg[proc_idx_reg] ? meta_t'(meta_rd_reg) : '0;
    assign cur_name = valid_reg[proc_idx_reg] ? name_rd_reg : '0;

    // scan results
    logic              found_reg;
    logic [IDX_W-1:0]  found_slot_reg;
    meta_t             found_meta_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_slot_reg;
    logic [16:0]       next_num_reg;
    logic [31:0]       place_reg;
    logic [NAME_W-1:0] slot0_name_reg;

    logic by_name;
    assign by_name = (func_reg == FN_OPEN_NAME) || (func_reg == FN_CREATE) ||
                     (func_reg == FN_DELETE);

    logic        used;
    logic        name_hit;
    logic        num_hit;
    logic [31:0] place_end;
    assign used      = (cur_meta.number != 16'd0);
    assign name_hit  = (cur_name[7:0] != 8'h00) &&
                       (((cur_name ^ qname_reg) & qmask_reg) == '0);
    assign num_hit   = (number_reg != 16'd0) && (cur_meta.number == number_reg);
    assign place_end = place_reg + size_reg;

    // result register
    logic [1:0]  res_status_reg;
    logic [7:0]  res_slot_reg;
    logic [15:0] res_num_reg;
    logic [31:0] res_len_reg;
    logic [31:0] res_raw_reg;
    logic        res_sync_reg;

    logic              out_vld_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // commit decisions
    logic              is_lookup;
    logic [IDX_W-1:0]  new_slot;
    logic [15:0]       new_num;
    logic [NAME_W-1:0] new_name;
    assign is_lookup = (func_reg == FN_OPEN_NAME) || (func_reg == FN_OPEN_NUM) ||
                       (func_reg == FN_ACCESS);
    assign new_slot  = free_found_reg ? free_slot_reg : '0;
    assign new_num   = next_num_reg[16] ? 16'hFFFF : next_num_reg[15:0];
    // a full table reuses slot 0 and keeps its name bytes past the query
    assign new_name  = ((free_found_reg ? '0 : slot0_name_reg) & ~qmask_reg) | qname_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = new_slot;
        wr_meta = {new_num, size_reg, place_reg};
        wr_name = new_name;
        if (state_reg == S_COMMIT)
        begin
            if (func_reg == FN_CREATE && !found_reg)
            begin
                wr_en = 1'b1;
            end
            else if (func_reg == FN_DELETE && found_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = found_slot_reg;
                wr_meta = '0;
                wr_name = '0;
            end
        end
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_axis_tvalid) state_next = S_SCAN;
            S_SCAN:   if (scan_addr_reg == IDX_W'(ENTRIES - 1)) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_COMMIT;
            S_COMMIT: state_next = S_FINISH;
            S_FINISH: if (!out_vld_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            data_start_reg <= DATA_START_RST;
            file_gap_reg   <= FILE_GAP_RST;
            valid_reg      <= '0;
            proc_vld_reg   <= 1'b0;
            scan_addr_reg  <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DATA_START: data_start_reg <= cfg_data;
                    CFG_FILE_GAP:   file_gap_reg   <= cfg_data[15:0];
                    default:        ;
                endcase
            end
            if (state_reg == S_IDLE)
                scan_addr_reg <= '0;
            else if (state_reg == S_SCAN)
                scan_addr_reg <= scan_addr_reg + 1'b1;
            proc_vld_reg <= (state_reg == S_SCAN);
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (out_vld_reg && m_axis_tready)
                out_vld_reg <= 1'b0;
            if (state_reg == S_FINISH && (!out_vld_reg || m_axis_tready))
                out_vld_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg <= scan_addr_reg;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            func_reg       <= in_func;
            number_reg     <= in_number;
            qname_reg      <= in_name & qmask_calc;
            qmask_reg      <= qmask_calc;
            size_reg       <= in_size;
            offset_reg     <= in_offset;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            next_num_reg   <= 17'd1;
            place_reg      <= data_start_reg;
        end
        if (proc_vld_reg)
        begin
            if (!found_reg && (by_name ? name_hit : num_hit))
            begin
                found_reg      <= 1'b1;
                found_slot_reg <= proc_idx_reg;
                found_meta_reg <= cur_meta;
            end
            if (!free_found_reg && !used)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= proc_idx_reg;
            end
            // running number scan
            if (used && {1'b0, cur_meta.number} <= next_num_reg)
                next_num_reg <= {1'b0, cur_meta.number} + 17'd1;
            // running placement scan
            if (used && cur_meta.raw <= place_end)
                place_reg <= cur_meta.raw + cur_meta.length + {16'd0, file_gap_reg};
            if (proc_idx_reg == '0)
                slot0_name_reg <= cur_name;
        end
        if (state_reg == S_COMMIT)
        begin
            res_status_reg <= ST_NO_FILE;
            res_slot_reg   <= '0;
            res_num_reg    <= '0;
            res_len_reg    <= '0;
            res_raw_reg    <= '0;
            res_sync_reg   <= 1'b0;
            if ((is_lookup || func_reg == FN_DELETE) && found_reg)
            begin
                res_status_reg <= ST_READY;
                res_slot_reg   <= 8'(found_slot_reg);
                res_num_reg    <= found_meta_reg.number;
                res_len_reg    <= found_meta_reg.length;
                res_raw_reg    <= (func_reg == FN_ACCESS) ?
                                  offset_reg + found_meta_reg.raw : found_meta_reg.raw;
                res_sync_reg   <= (func_reg == FN_DELETE);
            end
            else if (func_reg == FN_CREATE)
            begin
                if (found_reg)
                    res_status_reg <= ST_EXISTS;
                else
                begin
                    res_status_reg <= ST_READY;
                    res_slot_reg   <= 8'(new_slot);
                    res_num_reg    <= new_num;
                    res_len_reg    <= size_reg;
                    res_raw_reg    <= place_reg;
                    res_sync_reg   <= 1'b1;
                end
            end
        end
        if (state_reg == S_FINISH && (!out_vld_reg || m_axis_tready))
            out_data_reg <= {5'd0, res_sync_reg, res_raw_reg, res_len_reg,
                             res_num_reg, res_slot_reg, res_status_reg};
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
